@@ rtl/qau_pkg.sv @@
// Shared types, codes and tables for the quaternion arithmetic unit.
package qau_pkg;

    localparam int FIELD_BITS    = 32;
    localparam int LANES         = 4;
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_CONJ = 3'd3;
    localparam logic [2:0] CMD_NORM = 3'd4;
    localparam logic [2:0] CMD_INV  = 3'd5;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_CONJ,
        OP_NORM,
        OP_INV,
        OP_NONE
    } t_op;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_MUL,
        BK_SQ,
        BK_ROOT,
        BK_DIV
    } t_back_state;

    typedef struct packed {
        t_op                                op;
        logic [LANES-1:0][FIELD_BITS-1:0]   a;
        logic [LANES-1:0][FIELD_BITS-1:0]   b;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Hamilton product: B lane feeding each A lane, per result component
    localparam logic [1:0] MUL_BSEL [LANES][LANES] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    // Hamilton product: bit i set when term i is subtracted
    localparam logic [LANES-1:0] MUL_NEG [LANES] = '{
        4'b1110, 4'b1000, 4'b0010, 4'b0100
    };

endpackage

@@ rtl/qau_front.sv @@
// Front end: command handshake and decode of the command into an operation.
module qau_front (
    input  logic                                        start,
    input  logic [2:0]                                  i_command,
    input  logic [qau_pkg::LANES-1:0][qau_pkg::FIELD_BITS-1:0] i_a,
    input  logic [qau_pkg::LANES-1:0][qau_pkg::FIELD_BITS-1:0] i_b,
    input  qau_pkg::t_q_stat                            i_q_stat,
    output logic                                        busy,
    output logic                                        o_push,
    output qau_pkg::t_item                              o_item
);

    qau_pkg::t_op op;

    always_comb begin
        unique case (i_command)
            qau_pkg::CMD_ADD:  op = qau_pkg::OP_ADD;
            qau_pkg::CMD_SUB:  op = qau_pkg::OP_SUB;
            qau_pkg::CMD_MUL:  op = qau_pkg::OP_MUL;
            qau_pkg::CMD_CONJ: op = qau_pkg::OP_CONJ;
            qau_pkg::CMD_NORM: op = qau_pkg::OP_NORM;
            qau_pkg::CMD_INV:  op = qau_pkg::OP_INV;
            default:           op = qau_pkg::OP_NONE;
        endcase
    end

    assign busy      = i_q_stat.full;
    assign o_push    = start && !i_q_stat.full;
    assign o_item.op = op;
    assign o_item.a  = i_a;
    assign o_item.b  = i_b;

endmodule

@@ rtl/qau_queue.sv @@
// Small register FIFO between the front end and the execution back end.
module qau_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qau_pkg::t_item    i_item,
    input  logic              i_pop,
    output qau_pkg::t_item    o_head,
    output qau_pkg::t_q_stat  o_stat
);

    localparam int PTR_W = $clog2(qau_pkg::QUEUE_DEPTH);

    qau_pkg::t_item     r_mem [qau_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W:0]     r_count;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [PTR_W:0]     n_count;

    always_comb begin
        n_wr    = i_push ? r_wr + PTR_W'(1) : r_wr;
        n_rd    = i_pop  ? r_rd + PTR_W'(1) : r_rd;
        n_count = r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == (PTR_W+1)'(qau_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

@@ rtl/qau_back.sv @@
// Back end: add/sub/conjugate, pipelined Hamilton product, root and divide loops.
module qau_back #(
    parameter int WORD_BITS = qau_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = qau_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  qau_pkg::t_q_stat                  i_q_stat,
    input  qau_pkg::t_item                    i_head,
    output logic                              o_pop,
    output logic                              o_done,
    output logic [qau_pkg::FIELD_BITS-1:0]    o_r_w,
    output logic [qau_pkg::FIELD_BITS-1:0]    o_r_x,
    output logic [qau_pkg::FIELD_BITS-1:0]    o_r_y,
    output logic [qau_pkg::FIELD_BITS-1:0]    o_r_z,
    output logic                              o_overflow,
    output logic                              o_divide_by_zero
);

    localparam int FB       = qau_pkg::FIELD_BITS;
    localparam int LN       = qau_pkg::LANES;
    localparam int PROD_W   = 2 * FB;
    localparam int PAIR_W   = PROD_W + 1;
    localparam int SUM_W    = PROD_W + 2;
    localparam int QW       = FB + 2 * FRAC_BITS;
    localparam int XW       = ((QW > SUM_W) ? QW : SUM_W) + 2;
    localparam int CNT_W    = $clog2(QW + 1);
    localparam int REM_W    = FB + 4;
    localparam int ROOT_W   = FB;
    localparam int SH_CARRY = PROD_W - 2 * FRAC_BITS;
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(6);
    localparam logic [CNT_W-1:0] SQ_DECIDE = CNT_W'(3);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QW);
    localparam logic signed [XW-1:0] X_ONE  = 1;
    localparam logic signed [XW-1:0] SAT_HI = (X_ONE <<< (WORD_BITS - 1)) - X_ONE;
    localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - X_ONE;
    localparam logic signed [XW-1:0] CAP    = X_ONE <<< (WORD_BITS - 1);
    localparam logic signed [XW-1:0] ROOT_OVF = X_ONE <<< FB;

    // returns {overflow, low FB bits of the clamped value}
    function automatic logic [FB:0] sat_word(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] c;
        logic                 ov;
        c  = v;
        ov = 1'b0;
        if (v > SAT_HI) begin
            c  = SAT_HI;
            ov = 1'b1;
        end else if (v < SAT_LO) begin
            c  = SAT_LO;
            ov = 1'b1;
        end
        return {ov, c[FB-1:0]};
    endfunction

    // capped quotient magnitude with sign applied
    function automatic logic signed [XW-1:0] inv_value(input logic [QW-1:0] q,
                                                       input logic neg);
        logic signed [XW-1:0] qx;
        qx = XW'(q);
        if (qx > CAP) begin
            qx = CAP;
        end
        return neg ? -qx : qx;
    endfunction

    qau_pkg::t_back_state   r_state;
    qau_pkg::t_back_state   n_state;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    qau_pkg::t_op           r_op;

    logic signed [FB-1:0]     r_a    [LN];
    logic signed [FB-1:0]     r_b    [LN];
    logic signed [PROD_W-1:0] r_prod [LN];
    logic signed [PAIR_W-1:0] r_pair [2];
    logic signed [XW-1:0]     r_acc  [LN];
    logic signed [SUM_W-1:0]  r_s;
    logic [PROD_W-1:0]        r_rad;
    logic [REM_W-1:0]         r_srem;
    logic [ROOT_W-1:0]        r_root;
    logic [QW-1:0]            r_dvd  [LN];
    logic [QW-1:0]            r_q    [LN];
    logic [PROD_W-1:0]        r_drem [LN];

    // operand selection and products
    logic signed [FB-1:0]     mb     [LN];
    logic signed [PROD_W-1:0] prod   [LN];
    logic signed [PAIR_W-1:0] term   [LN];
    logic [LN-1:0]            neg_mask;
    logic [CNT_W-1:0]         cnt_m1;
    logic [CNT_W-1:0]         cnt_m2;
    logic signed [SUM_W-1:0]  sum4;

    // squared norm decode
    logic                     s_carry;
    logic [PROD_W-1:0]        s_lo;
    logic                     s_zero;
    logic [FB-1:0]            mag    [LN];
    logic                     cneg   [LN];

    // root step
    logic [REM_W-1:0]         srem_n;
    logic [REM_W-1:0]         strial;
    logic                     sge;

    // divide step
    logic [PROD_W:0]          drem_n [LN];
    logic                     dge    [LN];

    // finish
    logic                     fin;
    logic                     fin_dz;
    logic signed [XW-1:0]     fin_v  [LN];
    logic [FB:0]              fin_s  [LN];
    logic                     go_root;
    logic                     go_div;

    assign cnt_m1 = r_cnt - CNT_W'(1);
    assign cnt_m2 = r_cnt - CNT_W'(2);

    always_comb begin
        for (int i = 0; i < LN; i++) begin
            mb[i]   = (r_state == qau_pkg::BK_MUL) ? r_b[qau_pkg::MUL_BSEL[r_cnt[1:0]][i]]
                                                   : r_a[i];
            prod[i] = r_a[i] * mb[i];
        end
        neg_mask = (r_state == qau_pkg::BK_MUL) ? qau_pkg::MUL_NEG[cnt_m1[1:0]] : '0;
        for (int i = 0; i < LN; i++) begin
            term[i] = neg_mask[i] ? -PAIR_W'(r_prod[i]) : PAIR_W'(r_prod[i]);
        end
        sum4 = SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]);
    end

    always_comb begin
        s_carry = r_s[PROD_W];
        s_lo    = r_s[PROD_W-1:0];
        s_zero  = (r_s == '0);
        for (int i = 0; i < LN; i++) begin
            mag[i]  = r_a[i][FB-1] ? FB'(-r_a[i]) : FB'(r_a[i]);
            cneg[i] = (i == 0) ? r_a[i][FB-1] : (!r_a[i][FB-1] && (r_a[i] != '0));
        end
    end

    always_comb begin
        srem_n = {r_srem[REM_W-3:0], r_rad[PROD_W-1 -: 2]};
        strial = REM_W'({r_root, 2'b01});
        sge    = (srem_n >= strial);
        for (int i = 0; i < LN; i++) begin
            drem_n[i] = {r_drem[i], r_dvd[i][QW-1]};
            dge[i]    = (drem_n[i] >= {1'b0, s_lo});
        end
    end

    // result selection for the cycle in which an item completes
    always_comb begin
        fin     = 1'b0;
        fin_dz  = 1'b0;
        go_root = 1'b0;
        go_div  = 1'b0;
        for (int i = 0; i < LN; i++) begin
            fin_v[i] = '0;
        end
        unique case (r_state)
            qau_pkg::BK_EXEC: begin
                fin = 1'b1;
                for (int i = 0; i < LN; i++) begin
                    unique case (r_op)
                        qau_pkg::OP_ADD:  fin_v[i] = XW'(r_a[i]) + XW'(r_b[i]);
                        qau_pkg::OP_SUB:  fin_v[i] = XW'(r_a[i]) - XW'(r_b[i]);
                        qau_pkg::OP_CONJ: fin_v[i] = (i == 0) ? XW'(r_a[i]) : -XW'(r_a[i]);
                        default:          fin_v[i] = '0;
                    endcase
                end
            end
            qau_pkg::BK_MUL: begin
                if (r_cnt == MUL_LAST) begin
                    fin = 1'b1;
                    for (int i = 0; i < LN; i++) begin
                        fin_v[i] = r_acc[i];
                    end
                end
            end
            qau_pkg::BK_SQ: begin
                if (r_cnt == SQ_DECIDE) begin
                    if (r_op == qau_pkg::OP_NORM) begin
                        if (s_carry) begin
                            fin      = 1'b1;
                            fin_v[0] = ROOT_OVF;
                        end else begin
                            go_root = 1'b1;
                        end
                    end else if (s_zero) begin
                        fin    = 1'b1;
                        fin_dz = 1'b1;
                    end else if (s_carry) begin
                        // divisor is exactly 2^64: plain shift
                        fin = 1'b1;
                        for (int i = 0; i < LN; i++) begin
                            fin_v[i] = inv_value(QW'(mag[i]) >> SH_CARRY, cneg[i]);
                        end
                    end else begin
                        go_div = 1'b1;
                    end
                end
            end
            qau_pkg::BK_ROOT: begin
                if (r_cnt == ROOT_LAST) begin
                    fin      = 1'b1;
                    fin_v[0] = XW'(r_root);
                end
            end
            qau_pkg::BK_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    fin = 1'b1;
                    for (int i = 0; i < LN; i++) begin
                        fin_v[i] = inv_value(r_q[i], cneg[i]);
                    end
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase
        for (int i = 0; i < LN; i++) begin
            fin_s[i] = sat_word(fin_v[i]);
        end
        o_pop = !i_q_stat.empty && ((r_state == qau_pkg::BK_IDLE) || fin);
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        if (o_pop) begin
            n_cnt = '0;
            unique case (i_head.op)
                qau_pkg::OP_MUL:  n_state = qau_pkg::BK_MUL;
                qau_pkg::OP_NORM: n_state = qau_pkg::BK_SQ;
                qau_pkg::OP_INV:  n_state = qau_pkg::BK_SQ;
                default:          n_state = qau_pkg::BK_EXEC;
            endcase
        end else if (fin || (r_state == qau_pkg::BK_IDLE)) begin
            n_state = qau_pkg::BK_IDLE;
            n_cnt   = '0;
        end else if (go_root) begin
            n_state = qau_pkg::BK_ROOT;
            n_cnt   = '0;
        end else if (go_div) begin
            n_state = qau_pkg::BK_DIV;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qau_pkg::BK_IDLE;
            r_cnt   <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            o_done  <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_head.op;
            for (int i = 0; i < LN; i++) begin
                r_a[i] <= $signed(i_head.a[i]);
                r_b[i] <= $signed(i_head.b[i]);
            end
        end
        for (int i = 0; i < LN; i++) begin
            r_prod[i] <= prod[i];
        end
        r_pair[0] <= term[0] + term[1];
        r_pair[1] <= term[2] + term[3];
        if ((r_state == qau_pkg::BK_MUL) && (r_cnt >= CNT_W'(2))
                && (r_cnt < MUL_LAST)) begin
            r_acc[cnt_m2[1:0]] <= XW'(sum4 >>> FRAC_BITS);
        end
        if ((r_state == qau_pkg::BK_SQ) && (r_cnt == CNT_W'(2))) begin
            r_s <= sum4;
        end
        if (go_root) begin
            r_rad  <= s_lo;
            r_srem <= '0;
            r_root <= '0;
        end else if ((r_state == qau_pkg::BK_ROOT) && (r_cnt < ROOT_LAST)) begin
            r_rad  <= {r_rad[PROD_W-3:0], 2'b00};
            r_srem <= sge ? srem_n - strial : srem_n;
            r_root <= {r_root[ROOT_W-2:0], sge};
        end
        for (int i = 0; i < LN; i++) begin
            if (go_div) begin
                r_dvd[i]  <= QW'(mag[i]) << (2 * FRAC_BITS);
                r_q[i]    <= '0;
                r_drem[i] <= '0;
            end else if ((r_state == qau_pkg::BK_DIV) && (r_cnt < DIV_LAST)) begin
                r_dvd[i]  <= {r_dvd[i][QW-2:0], 1'b0};
                r_q[i]    <= {r_q[i][QW-2:0], dge[i]};
                r_drem[i] <= dge[i] ? PROD_W'(drem_n[i] - {1'b0, s_lo})
                                    : PROD_W'(drem_n[i]);
            end
        end
        if (fin) begin
            o_r_w            <= fin_s[0][FB-1:0];
            o_r_x            <= fin_s[1][FB-1:0];
            o_r_y            <= fin_s[2][FB-1:0];
            o_r_z            <= fin_s[3][FB-1:0];
            o_overflow       <= fin_s[0][FB] | fin_s[1][FB] | fin_s[2][FB] | fin_s[3][FB];
            o_divide_by_zero <= fin_dz;
        end
    end

endmodule

@@ rtl/quaternion_arithmetic_unit.sv @@
// Top level of the quaternion arithmetic unit: front end, queue, back end.
//
// Quaternion ALU in signed fixed point (FRAC_BITS fraction bits, Q16.16 by
// default). A beat is taken when start is high and busy is low; busy rises
// only when the four-entry queue between the decoder and the execution
// unit is full. Each result appears for exactly one cycle with o_done high
// and cannot be held off, so the consumer must take every o_done beat.
// Results come out in command order. Back-end work per beat:
//   add, subtract, conjugate, unknown command : BK_EXEC (one per clock)
//   multiply : four shared 32x32 multipliers, one result component
//              per cycle, then two adder stages
//   norm     : squaring and summing, then the one-bit-per-cycle
//              square root loop
//   inverse  : squaring and summing, then four parallel restoring
//              dividers over a 32 + 2*FRAC_BITS bit quotient (64 at
//              Q16.16); an inverse of zero, or a norm or inverse whose
//              squared norm reaches 2^64, finishes after the squaring.
// From start to o_done a beat passes the queue register, the back end
// and the output register, plus any wait behind earlier beats. Any
// component that saturates to the WORD_BITS range sets o_overflow.
module quaternion_arithmetic_unit #(
    parameter int WORD_BITS = qau_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = qau_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        i_command,
    input  logic [qau_pkg::FIELD_BITS-1:0]    i_a_w,
    input  logic [qau_pkg::FIELD_BITS-1:0]    i_a_x,
    input  logic [qau_pkg::FIELD_BITS-1:0]    i_a_y,
    input  logic [qau_pkg::FIELD_BITS-1:0]    i_a_z,
    input  logic [qau_pkg::FIELD_BITS-1:0]    i_b_w,
    input  logic [qau_pkg::FIELD_BITS-1:0]    i_b_x,
    input  logic [qau_pkg::FIELD_BITS-1:0]    i_b_y,
    input  logic [qau_pkg::FIELD_BITS-1:0]    i_b_z,
    output logic                              o_done,
    output logic [qau_pkg::FIELD_BITS-1:0]    o_r_w,
    output logic [qau_pkg::FIELD_BITS-1:0]    o_r_x,
    output logic [qau_pkg::FIELD_BITS-1:0]    o_r_y,
    output logic [qau_pkg::FIELD_BITS-1:0]    o_r_z,
    output logic                              o_overflow,
    output logic                              o_divide_by_zero
);

    qau_pkg::t_item     push_item;
    qau_pkg::t_item     head_item;
    qau_pkg::t_q_stat   q_stat;
    logic               push;
    logic               pop;

    // lane order w, x, y, z
    qau_front u_front (
        .start     (start),
        .i_command (i_command),
        .i_a       ({i_a_z, i_a_y, i_a_x, i_a_w}),
        .i_b       ({i_b_z, i_b_y, i_b_x, i_b_w}),
        .i_q_stat  (q_stat),
        .busy      (busy),
        .o_push    (push),
        .o_item    (push_item)
    );

    qau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_stat  (q_stat)
    );

    qau_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_stat         (q_stat),
        .i_head           (head_item),
        .o_pop            (pop),
        .o_done           (o_done),
        .o_r_w            (o_r_w),
        .o_r_x            (o_r_x),
        .o_r_y            (o_r_y),
        .o_r_z            (o_r_z),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule
